[sv/bidirectional_mailbox_rings_macros.svh]
// Assertion helpers for the mailbox ring RTL.
// Each macro takes a label, the clock, the active-low reset, the
// antecedent, the consequent and a message.
`ifndef BIDIRECTIONAL_MAILBOX_RINGS_MACROS_SVH
`define BIDIRECTIONAL_MAILBOX_RINGS_MACROS_SVH

`ifndef SYNTHESIS

`define BMR_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BMR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BMR_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)

`define BMR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/bmr_pkg.sv]
`timescale 1ns / 1ps

package bmr_pkg;

    localparam int RING_SLOTS_DEF = 16;

    localparam int HANDLE_W = 32;
    localparam int LEN_IN_W = 32;
    localparam int LEN_W    = 31;
    localparam int MSG_W    = HANDLE_W + LEN_W;

    localparam logic [LEN_W-1:0] LEN_CAP = {LEN_W{1'b1}};

    // Register map: one register, decoded on paddr[2].
    localparam int   PADDR_W          = 3;
    localparam logic REG_THREAD_WAKE  = 1'b0;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLOSE = 2'd2,
        ACT_OPEN  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_WOULD_BLOCK = 2'd1,
        ST_PEER_CLOSED = 2'd2
    } status_t;

    typedef struct packed {
        action_t              action;
        logic                 side;
        logic [HANDLE_W-1:0]  msg_handle;
        logic [LEN_IN_W-1:0]  msg_len;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [LEN_W-1:0]     accepted_len;
        logic [HANDLE_W-1:0]  out_handle;
        logic [LEN_W-1:0]     out_len;
        logic                 end_of_stream;
        logic                 wake_loop;
        logic                 wake_thread;
        logic                 readable;
        logic                 writable;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctl_t;

    // single: exactly one entry; near_full: one free slot before full.
    typedef struct packed {
        logic empty;
        logic full;
        logic single;
        logic near_full;
    } ring_stat_t;

endpackage

[sv/bmr_ring.sv]
`timescale 1ns / 1ps

`include "bidirectional_mailbox_rings_macros.svh"

module bmr_ring
    import bmr_pkg::*;
#(
    parameter int RING_SLOTS = RING_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ring_ctl_t        ctl,
    input  logic [MSG_W-1:0] wdata,
    output ring_stat_t       stat,
    output logic [MSG_W-1:0] rdata
);

    localparam int PTR_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_SLOTS - 1);

    logic [MSG_W-1:0] mem [RING_SLOTS];
    logic [MSG_W-1:0] rdata_reg;

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] head_inc2;
    logic [PTR_W-1:0] tail_inc;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST) ? '0 : p + 1'b1;
    endfunction

    assign head_inc  = ptr_inc(head_reg);
    assign head_inc2 = ptr_inc(head_inc);
    assign tail_inc  = ptr_inc(tail_reg);

    assign stat.empty     = (head_reg == tail_reg);
    assign stat.full      = (head_inc == tail_reg);
    assign stat.single    = (tail_inc == head_reg);
    assign stat.near_full = (head_inc2 == tail_reg);

    assign head_next = ctl.push ? head_inc : head_reg;
    assign tail_next = ctl.pop  ? tail_inc : tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // The read port prefetches the entry at the next tail, so the oldest
    // message is ready at the start of every cycle. A write into that very
    // slot (the ring is empty once any pop is done) is forwarded.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[head_reg] <= wdata;
        end
        if (ctl.push && (head_reg == tail_next))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[tail_next];
        end
    end

    assign rdata = rdata_reg;

    `BMR_ASSERT_SAME(a_no_push_full, clk, rst_n, ctl.push, !stat.full, "push into full ring")
    `BMR_ASSERT_SAME(a_no_pop_empty, clk, rst_n, ctl.pop, !stat.empty, "pop from empty ring")
    `BMR_ASSERT_SAME(a_not_both, clk, rst_n, stat.empty, !stat.full, "ring empty and full")
    `BMR_ASSERT_NEXT(a_push_fills, clk, rst_n, ctl.push, !stat.empty, "ring empty after push")

endmodule

[sv/bmr_core.sv]
`timescale 1ns / 1ps

module bmr_core
    import bmr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  item_t            item,
    input  logic             thread_wake_enable,
    input  ring_stat_t       to_loop_stat,
    input  ring_stat_t       to_thread_stat,
    input  logic [MSG_W-1:0] to_loop_rdata,
    input  logic [MSG_W-1:0] to_thread_rdata,
    output ring_ctl_t        to_loop_ctl,
    output ring_ctl_t        to_thread_ctl,
    output result_t          result
);

    logic loop_open_reg;
    logic loop_open_next;
    logic thread_open_reg;
    logic thread_open_next;
    logic loop_closed_reg;
    logic loop_closed_next;
    logic thread_closed_reg;
    logic thread_closed_next;

    logic             loop_wake_ok;
    logic             thread_wake_ok;
    logic             peer_shut;
    ring_stat_t       rx_stat;
    ring_stat_t       tx_stat;
    logic [MSG_W-1:0] rx_data;
    logic [LEN_W-1:0] len_sat;
    logic             push;
    logic             pop;
    logic             rx_empty_after;
    logic             tx_full_after;

    assign loop_wake_ok   = loop_open_reg && !loop_closed_reg;
    assign thread_wake_ok = thread_open_reg && !thread_closed_reg && thread_wake_enable;

    // Side 1 (thread) reads the ring toward the thread and writes toward the loop.
    assign peer_shut = item.side ? loop_closed_reg : thread_closed_reg;
    assign rx_stat   = item.side ? to_thread_stat  : to_loop_stat;
    assign tx_stat   = item.side ? to_loop_stat    : to_thread_stat;
    assign rx_data   = item.side ? to_thread_rdata : to_loop_rdata;

    assign len_sat = item.msg_len[LEN_IN_W-1] ? LEN_CAP : item.msg_len[LEN_W-1:0];

    always_comb
    begin
        result             = '0;
        result.status      = ST_OK;
        push               = 1'b0;
        pop                = 1'b0;
        loop_open_next     = loop_open_reg;
        thread_open_next   = thread_open_reg;
        loop_closed_next   = loop_closed_reg;
        thread_closed_next = thread_closed_reg;

        case (item.action)
            ACT_WRITE:
            begin
                // A zero-length write succeeds without touching the ring.
                if (item.msg_len != '0)
                begin
                    if (peer_shut)
                    begin
                        result.status = ST_PEER_CLOSED;
                    end
                    else if (tx_stat.full)
                    begin
                        result.status = ST_WOULD_BLOCK;
                    end
                    else
                    begin
                        push                = 1'b1;
                        result.accepted_len = len_sat;
                        result.wake_loop    = item.side && loop_wake_ok;
                        result.wake_thread  = !item.side && thread_wake_ok;
                    end
                end
            end
            ACT_READ:
            begin
                if (!rx_stat.empty)
                begin
                    pop               = 1'b1;
                    result.out_handle = rx_data[HANDLE_W-1:0];
                    result.out_len    = rx_data[MSG_W-1:HANDLE_W];
                    // Draining a full ring lets the peer producer go on.
                    result.wake_loop   = rx_stat.full && item.side && loop_wake_ok;
                    result.wake_thread = rx_stat.full && !item.side && thread_wake_ok;
                end
                else if (peer_shut)
                begin
                    result.end_of_stream = 1'b1;
                end
                else
                begin
                    result.status = ST_WOULD_BLOCK;
                end
            end
            ACT_CLOSE:
            begin
                if (item.side)
                begin
                    thread_closed_next = 1'b1;
                    result.wake_loop   = loop_wake_ok;
                end
                else
                begin
                    loop_closed_next   = 1'b1;
                    result.wake_thread = thread_wake_ok;
                end
            end
            ACT_OPEN:
            begin
                // The loop side is woken on open even if it has closed.
                if (item.side)
                begin
                    thread_open_next   = 1'b1;
                    result.wake_thread = !to_thread_stat.empty && !thread_closed_reg
                                         && thread_wake_enable;
                end
                else
                begin
                    loop_open_next   = 1'b1;
                    result.wake_loop = !to_loop_stat.empty;
                end
            end
            default:
            begin
                result.status = ST_OK;
            end
        endcase

        rx_empty_after  = pop ? rx_stat.single : rx_stat.empty;
        tx_full_after   = push ? tx_stat.near_full : tx_stat.full;
        result.readable = !rx_empty_after || peer_shut;
        result.writable = !peer_shut && !tx_full_after;
    end

    assign to_loop_ctl.push   = advance && push && item.side;
    assign to_loop_ctl.pop    = advance && pop && !item.side;
    assign to_thread_ctl.push = advance && push && !item.side;
    assign to_thread_ctl.pop  = advance && pop && item.side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_open_reg     <= 1'b0;
            thread_open_reg   <= 1'b0;
            loop_closed_reg   <= 1'b0;
            thread_closed_reg <= 1'b0;
        end
        else if (advance)
        begin
            loop_open_reg     <= loop_open_next;
            thread_open_reg   <= thread_open_next;
            loop_closed_reg   <= loop_closed_next;
            thread_closed_reg <= thread_closed_next;
        end
    end

endmodule

[sv/bidirectional_mailbox_rings.sv]
// A request accepted into the input register moves on into the output
// register when that is free; with m_tready held high, one request per cycle.
// The input register, the ring pointers with a prefetched read slot, and the
// output register set the rate; a stalled output holds the input side after one entry.
// Reset (rst_n low, asynchronous) empties both rings, clears open, closed and
// wake-enable flags; ring slot contents are not cleared.
`timescale 1ns / 1ps

module bidirectional_mailbox_rings
    import bmr_pkg::*;
#(
    parameter int RING_SLOTS = RING_SLOTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [63:0]        s_tdata,   // msg_handle[31:0], msg_len[63:32]
    input  logic [2:0]         s_tuser,   // action[1:0], side[2]

    output logic               m_tvalid,
    input  logic               m_tready,
    // status[1:0], accepted_len[32:2], out_handle[64:33], out_len[95:65],
    // end_of_stream[96], wake_loop[97], wake_thread[98], readable[99],
    // writable[100], zero fill[103:101]
    output logic [103:0]       m_tdata,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    logic       twe_reg;
    logic       advance;

    ring_ctl_t        to_loop_ctl;
    ring_ctl_t        to_thread_ctl;
    ring_stat_t       to_loop_stat;
    ring_stat_t       to_thread_stat;
    logic [MSG_W-1:0] to_loop_rdata;
    logic [MSG_W-1:0] to_thread_rdata;
    logic [MSG_W-1:0] to_loop_wdata;
    logic [MSG_W-1:0] to_thread_wdata;
    result_t          result;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THREAD_WAKE) ? {31'b0, twe_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twe_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_THREAD_WAKE))
        begin
            twe_reg <= pwdata[0];
        end
    end

    // A request moves from the input register into the output register when
    // the output register is free or is being emptied in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.action     <= action_t'(s_tuser[1:0]);
            in_item_reg.side       <= s_tuser[2];
            in_item_reg.msg_handle <= s_tdata[31:0];
            in_item_reg.msg_len    <= s_tdata[63:32];
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    // Both rings store {length, handle}; only one is pushed per request.
    assign to_loop_wdata   = {(in_item_reg.msg_len[LEN_IN_W-1] ? LEN_CAP
                                  : in_item_reg.msg_len[LEN_W-1:0]),
                              in_item_reg.msg_handle};
    assign to_thread_wdata = to_loop_wdata;

    bmr_ring #(
        .RING_SLOTS (RING_SLOTS)
    ) u_to_loop (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (to_loop_ctl),
        .wdata (to_loop_wdata),
        .stat  (to_loop_stat),
        .rdata (to_loop_rdata)
    );

    bmr_ring #(
        .RING_SLOTS (RING_SLOTS)
    ) u_to_thread (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (to_thread_ctl),
        .wdata (to_thread_wdata),
        .stat  (to_thread_stat),
        .rdata (to_thread_rdata)
    );

    bmr_core u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (advance),
        .item               (in_item_reg),
        .thread_wake_enable (twe_reg),
        .to_loop_stat       (to_loop_stat),
        .to_thread_stat     (to_thread_stat),
        .to_loop_rdata      (to_loop_rdata),
        .to_thread_rdata    (to_thread_rdata),
        .to_loop_ctl        (to_loop_ctl),
        .to_thread_ctl      (to_thread_ctl),
        .result             (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b0,
                       out_result_reg.writable,
                       out_result_reg.readable,
                       out_result_reg.wake_thread,
                       out_result_reg.wake_loop,
                       out_result_reg.end_of_stream,
                       out_result_reg.out_len,
                       out_result_reg.out_handle,
                       out_result_reg.accepted_len,
                       out_result_reg.status};

endmodule

[bench/mailbox_checker.sv]
`timescale 1ns / 1ps

module mailbox_checker
    import bmr_pkg::*;
#(
    parameter int SLOTS = RING_SLOTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [63:0]        s_tdata,   // msg_handle[31:0], msg_len[63:32]
    input  logic [2:0]         s_tuser,   // action[1:0], side[2]
    input  logic               m_tvalid,
    input  logic               m_tready,
    // status[1:0], accepted_len[32:2], out_handle[64:33], out_len[95:65],
    // end_of_stream[96], wake_loop[97], wake_thread[98], readable[99],
    // writable[100], zero fill[103:101]
    input  logic [103:0]       m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 mismatches,
    output int                 pending,
    output int                 results_seen,
    output int                 blocked_seen,
    output int                 refused_seen,
    output int                 eos_seen,
    output int                 wakes_seen
);

    // Ring 0 carries messages toward the loop side and ring 1 toward the thread
    // side, so a side reads the ring of its own index and writes the other one.
    logic [HANDLE_W-1:0] slot_handle [2][SLOTS];
    logic [LEN_W-1:0]    slot_len    [2][SLOTS];
    int unsigned         head        [2];
    int unsigned         tail        [2];
    logic                opened      [2];
    logic                closed      [2];
    logic                thread_wake_en;
    result_t             expected_q  [$];

    function automatic int unsigned next_slot(int unsigned p);
        return (p + 1 >= SLOTS) ? 0 : p + 1;
    endfunction

    function automatic logic ring_empty(logic r);
        return head[r] == tail[r];
    endfunction

    function automatic logic ring_full(logic r);
        return next_slot(head[r]) == tail[r];
    endfunction

    // The thread side (index 1) also needs its wake handler registered.
    function automatic logic wake_allowed(logic s);
        return opened[s] && !closed[s] && (!s || thread_wake_en);
    endfunction

    function automatic result_t predict_result(item_t req);
        result_t          res;
        logic             s;
        logic             peer;
        logic             full_before_read;
        logic [1:0]       wake;
        logic [LEN_W-1:0] len;
        s    = req.side;
        peer = !s;
        wake = 2'b00;
        res  = '0;
        res.status = ST_OK;
        case (req.action)
            ACT_WRITE:
            begin
                // A zero-length write succeeds without touching the ring or the flags.
                if (req.msg_len != 0)
                begin
                    len = (req.msg_len > LEN_CAP) ? LEN_CAP : req.msg_len[LEN_W-1:0];
                    if (closed[peer])
                        res.status = ST_PEER_CLOSED;
                    else if (ring_full(peer))
                        res.status = ST_WOULD_BLOCK;
                    else
                    begin
                        slot_handle[peer][head[peer]] = req.msg_handle;
                        slot_len[peer][head[peer]]    = len;
                        head[peer]       = next_slot(head[peer]);
                        res.accepted_len = len;
                        wake[peer]       = wake_allowed(peer);
                    end
                end
            end
            ACT_READ:
            begin
                full_before_read = ring_full(s);
                if (!ring_empty(s))
                begin
                    res.out_handle = slot_handle[s][tail[s]];
                    res.out_len    = slot_len[s][tail[s]];
                    tail[s]        = next_slot(tail[s]);
                    if (full_before_read)
                        wake[peer] = wake_allowed(peer);
                end
                else if (closed[peer])
                    res.end_of_stream = 1'b1;
                else
                    res.status = ST_WOULD_BLOCK;
            end
            ACT_CLOSE:
            begin
                closed[s]  = 1'b1;
                wake[peer] = wake_allowed(peer);
            end
            ACT_OPEN:
            begin
                opened[s] = 1'b1;
                // Opening the loop side wakes it even when it has already closed.
                if (!ring_empty(s))
                    wake[s] = s ? wake_allowed(s) : 1'b1;
            end
        endcase
        res.wake_loop   = wake[0];
        res.wake_thread = wake[1];
        res.readable    = !ring_empty(s) || closed[peer];
        res.writable    = !closed[peer] && !ring_full(peer);
        return res;
    endfunction

    function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatches++;
    endfunction

    function automatic void compare_result(result_t want, result_t got);
        if (want.status !== got.status)
            report_field("status", want.status, got.status);
        if (want.accepted_len !== got.accepted_len)
            report_field("accepted_len", want.accepted_len, got.accepted_len);
        if (want.out_handle !== got.out_handle)
            report_field("out_handle", want.out_handle, got.out_handle);
        if (want.out_len !== got.out_len)
            report_field("out_len", want.out_len, got.out_len);
        if (want.end_of_stream !== got.end_of_stream)
            report_field("end_of_stream", want.end_of_stream, got.end_of_stream);
        if (want.wake_loop !== got.wake_loop)
            report_field("wake_loop", want.wake_loop, got.wake_loop);
        if (want.wake_thread !== got.wake_thread)
            report_field("wake_thread", want.wake_thread, got.wake_thread);
        if (want.readable !== got.readable)
            report_field("readable", want.readable, got.readable);
        if (want.writable !== got.writable)
            report_field("writable", want.writable, got.writable);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        item_t   req;
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < 2; r++)
            begin
                head[r]   = 0;
                tail[r]   = 0;
                opened[r] = 1'b0;
                closed[r] = 1'b0;
            end
            thread_wake_en = 1'b0;
            expected_q.delete();
            pending      = 0;
            mismatches   = 0;
            results_seen = 0;
            blocked_seen = 0;
            refused_seen = 0;
            eos_seen     = 0;
            wakes_seen   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status        = status_t'(m_tdata[1:0]);
                got.accepted_len  = m_tdata[32:2];
                got.out_handle    = m_tdata[64:33];
                got.out_len       = m_tdata[95:65];
                got.end_of_stream = m_tdata[96];
                got.wake_loop     = m_tdata[97];
                got.wake_thread   = m_tdata[98];
                got.readable      = m_tdata[99];
                got.writable      = m_tdata[100];
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $display({"%0t ns: result with no request outstanding, ",
                              "expected none, actual %h"}, $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_result(want, got);
                end
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_THREAD_WAKE)
                thread_wake_en = pwdata[0];
            if (s_tvalid && s_tready)
            begin
                req.action     = action_t'(s_tuser[1:0]);
                req.side       = s_tuser[2];
                req.msg_handle = s_tdata[31:0];
                req.msg_len    = s_tdata[63:32];
                want = predict_result(req);
                if (want.status == ST_WOULD_BLOCK)
                    blocked_seen++;
                if (want.status == ST_PEER_CLOSED)
                    refused_seen++;
                if (want.end_of_stream)
                    eos_seen++;
                if (want.wake_loop || want.wake_thread)
                    wakes_seen++;
                expected_q.push_back(want);
            end
            pending = expected_q.size();
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import bmr_pkg::*;

    localparam logic SIDE_LOOP      = 1'b0;
    localparam logic SIDE_THREAD    = 1'b1;
    localparam int   RX_HOLD_CYCLES = 300;
    localparam int   IDLE_LIMIT     = 3000;
    localparam int   MIX_PHASES     = 8;
    localparam int   PHASE_REQUESTS = 180;
    localparam int   BURST_REQUESTS = 40;
    localparam int   CLOSE_REQUESTS = 100;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [63:0]        s_tdata;   // msg_handle[31:0], msg_len[63:32]
    logic [2:0]         s_tuser;   // action[1:0], side[2]
    logic               m_tvalid;
    logic               m_tready;
    // status[1:0], accepted_len[32:2], out_handle[64:33], out_len[95:65],
    // end_of_stream[96], wake_loop[97], wake_thread[98], readable[99],
    // writable[100], zero fill[103:101]
    logic [103:0]       m_tdata;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int          mismatches;
    int          pending;
    int          results_seen;
    int          blocked_seen;
    int          refused_seen;
    int          eos_seen;
    int          wakes_seen;
    bit          tx_steady;
    bit          rx_steady;
    int          hold_asks;
    int          hold_done;
    int unsigned rx_wait;
    int          stuck_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    bidirectional_mailbox_rings uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mailbox_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .blocked_seen (blocked_seen),
        .refused_seen (refused_seen),
        .eos_seen     (eos_seen),
        .wakes_seen   (wakes_seen)
    );

    // Result side: a random stall after every result taken unless rx_steady is set, or a long hold-off on request.
    initial
    begin
        m_tready  = 1'b0;
        rx_wait   = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                rx_wait = rx_steady ? 0 : $urandom_range(0, 11);
            @(negedge clk);
            if (hold_done != hold_asks)
            begin
                rx_wait   = RX_HOLD_CYCLES;
                hold_done = hold_asks;
            end
            if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stuck_cycles <= 0;
        else if (stuck_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no request or result moved for %0d cycles.", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic send_request(action_t act, logic side, logic [31:0] handle,
                                logic [31:0] len);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {len, handle};
        s_tuser  <= {side, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_len();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000 | $urandom;
            3, 4:    return $urandom_range(1, 64);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_handle();
        case ($urandom_range(0, 15))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // write_pct gives, per issuing side, how often a request is a write rather than a read.
    task automatic send_mix(int count, int write_pct_loop, int write_pct_thread);
        logic    side;
        int      pick;
        action_t act;
        for (int i = 0; i < count; i++)
        begin
            side = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 3)
                act = ACT_OPEN;
            else if (pick < (side ? write_pct_thread : write_pct_loop))
                act = ACT_WRITE;
            else
                act = ACT_READ;
            send_request(act, side, random_handle(), random_len());
        end
    endtask

    // Drop valid and wait until every result has been taken.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_wake_enable(logic enable);
        logic [31:0] data;
        data    = $urandom;
        data[0] = enable;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_THREAD_WAKE, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        hold_asks = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_wake_enable(1'b0);

        // Neither side is open yet, so these writes raise no wake.
        send_request(ACT_READ,  SIDE_LOOP,   32'h0000_0000, 32'h0000_0000);
        send_request(ACT_WRITE, SIDE_LOOP,   32'h1234_5678, 32'h0000_0000);
        send_request(ACT_WRITE, SIDE_THREAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_WRITE, SIDE_THREAD, 32'h0000_0000, 32'h0000_0001);
        send_request(ACT_WRITE, SIDE_LOOP,   32'h8000_0000, 32'h8000_0000);
        send_request(ACT_WRITE, SIDE_LOOP,   32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(ACT_OPEN,  SIDE_LOOP,   32'h0000_0000, 32'h0000_0000);
        send_request(ACT_OPEN,  SIDE_THREAD, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_WRITE, SIDE_THREAD, 32'h5A5A_5A5A, 32'h0000_0005);
        send_request(ACT_READ,  SIDE_LOOP,   32'h0000_0000, 32'h0000_0000);
        send_request(ACT_READ,  SIDE_THREAD, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_WRITE, SIDE_THREAD, 32'hFFFF_FFFF, 32'h0000_0000);
        settle();
        write_wake_enable(1'b1);
        send_request(ACT_WRITE, SIDE_LOOP,   32'hA5A5_A5A5, 32'h0000_0003);
        send_request(ACT_READ,  SIDE_THREAD, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_READ,  SIDE_THREAD, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_READ,  SIDE_THREAD, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_OPEN,  SIDE_THREAD, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_OPEN,  SIDE_LOOP,   32'h0000_0000, 32'h0000_0000);
        for (int i = 0; i < 3; i++)
            send_request(ACT_READ, SIDE_LOOP, 32'h0000_0000, 32'h0000_0000);
        settle();

        // Write-heavy and read-heavy mixes per side fill and drain both rings.
        for (int phase = 0; phase < MIX_PHASES; phase++)
        begin
            tx_steady = ($urandom_range(0, 2) == 0);
            rx_steady = ($urandom_range(0, 2) == 0);
            if (phase == 3)
            begin
                // Hold the result side off while requests keep coming back to back.
                tx_steady = 1'b1;
                hold_asks++;
                send_mix(BURST_REQUESTS, 50, 50);
            end
            send_mix(PHASE_REQUESTS, 20 + 30 * $urandom_range(0, 2),
                     20 + 30 * $urandom_range(0, 2));
            settle();
            write_wake_enable(phase[0]);
        end

        // Shutdown: the loop side closes first, then the thread side, and both drain.
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        send_request(ACT_CLOSE, SIDE_LOOP, 32'h0000_0000, 32'h0000_0000);
        send_mix(CLOSE_REQUESTS, 60, 60);
        settle();
        write_wake_enable(1'b1);
        send_request(ACT_CLOSE, SIDE_THREAD, 32'h0000_0000, 32'h0000_0000);
        send_mix(CLOSE_REQUESTS, 20, 20);
        send_request(ACT_CLOSE, SIDE_LOOP,   32'h0000_0000, 32'h0000_0000);
        send_request(ACT_CLOSE, SIDE_THREAD, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_READ,  SIDE_LOOP,   32'h0000_0000, 32'h0000_0000);
        send_request(ACT_READ,  SIDE_THREAD, 32'h0000_0000, 32'h0000_0000);
        settle();
        repeat (10) @(negedge clk);

        $display("Mailbox run: %0d results checked, %0d would-block, %0d refused as closed,",
                 results_seen, blocked_seen, refused_seen);
        $display("%0d end-of-stream reads and %0d requests raising a wake pulse.",
                 eos_seen, wakes_seen);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
